/* hw/rtl/fbfl_pkg.sv */
package fbfl_pkg;

    // default pool geometry
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_BLOCK_BYTES = 1024;

    // fixed field widths
    localparam int POOL_W   = 20;
    localparam int REQ_W    = 16;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_INIT    = 2'd2,
        MODE_DESTROY = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_REFUSED   = 3'd4
    } t_status;

endpackage

/* hw/rtl/fbfl_ram.sv */
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/fbfl_out_slot.sv */
module fbfl_out_slot #(
    parameter int DATA_W = 8,
    parameter int USER_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic [USER_W-1:0] i_user,
    output logic              o_push_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic [USER_W-1:0] o_user
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic [USER_W-1:0] r_user;

    // slot frees up in the same cycle it drains
    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
            r_user <= i_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

endmodule

/* hw/rtl/fbfl_ctrl.sv */
module fbfl_ctrl #(
    parameter int MAX_BLOCKS  = fbfl_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = fbfl_pkg::DEF_BLOCK_BYTES,
    localparam int IDX_W  = $clog2(MAX_BLOCKS),
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1),
    localparam int SIZE_W = $clog2(BLOCK_BYTES + 1),
    localparam int ENT_W  = LINK_W + SIZE_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pool size register
    input  logic                         i_cfg_wr_en,
    input  logic [fbfl_pkg::POOL_W-1:0]  i_cfg_wr_data,
    // incoming transaction
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fbfl_pkg::t_mode              i_mode,
    input  logic [fbfl_pkg::REQ_W-1:0]   i_req,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic                         i_is_null,
    // entry memory
    output logic                         o_ram_we,
    output logic [IDX_W-1:0]             o_ram_waddr,
    output logic [ENT_W-1:0]             o_ram_wdata,
    output logic                         o_ram_re,
    output logic [IDX_W-1:0]             o_ram_raddr,
    input  logic [ENT_W-1:0]             i_ram_rdata,
    // result to output slot
    input  logic                         i_push_ready,
    output logic                         o_push,
    output fbfl_pkg::t_status            o_push_status,
    output logic [IDX_W-1:0]             o_push_grant
);

    import fbfl_pkg::*;

    localparam int ACC_W = $clog2((MAX_BLOCKS + 2) * BLOCK_BYTES + 1);
    localparam int CMP_W = (ACC_W > POOL_W) ? ACC_W : POOL_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [REQ_W:0]    BB_REQ    = (REQ_W + 1)'(BLOCK_BYTES);
    localparam logic [POOL_W-1:0] BB_POOL   = POOL_W'(BLOCK_BYTES);
    localparam logic [ACC_W-1:0]  BB_ACC    = ACC_W'(BLOCK_BYTES);
    localparam logic [ACC_W-1:0]  ACC_START = ACC_W'(2 * BLOCK_BYTES);

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [LINK_W-1:0]  r_head, n_head;
    logic [POOL_W-1:0]  r_pool;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_init, n_init;
    logic               r_reply, n_reply;
    t_mode              r_mode, n_mode;
    logic [SIZE_W-1:0]  r_req, n_req;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_grant, n_grant;

    logic [REQ_W:0]     req_ext;
    logic               too_large;
    logic               head_null;
    logic               idx_out;
    logic               pool_small;
    logic               link_more;
    logic [LINK_W-1:0]  sweep_link;
    logic [LINK_W-1:0]  rd_link;
    logic [SIZE_W-1:0]  rd_size;
    logic [LINK_W-1:0]  rd_link_sat;

    assign req_ext    = {1'b0, i_req};
    assign too_large  = req_ext > BB_REQ;
    assign head_null  = r_head >= NULL_LINK;
    assign idx_out    = LINK_W'(i_idx) >= NULL_LINK;
    assign pool_small = r_pool <= BB_POOL;

    // entry r_addr links on while (r_addr + 2) blocks still fit the pool
    assign link_more  = CMP_W'(r_acc) <= CMP_W'(r_pool);
    assign sweep_link = (r_init && (r_addr != LAST_ADDR) && link_more)
                        ? LINK_W'(r_addr) + LINK_W'(1) : NULL_LINK;

    assign rd_link     = i_ram_rdata[SIZE_W +: LINK_W];
    assign rd_size     = i_ram_rdata[SIZE_W-1:0];
    assign rd_link_sat = (rd_link > NULL_LINK) ? NULL_LINK : rd_link;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= '0;
        end else if (i_cfg_wr_en) begin
            r_pool <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_addr   = r_addr;
        n_acc    = r_acc;
        n_init   = r_init;
        n_reply  = r_reply;
        n_mode   = r_mode;
        n_req    = r_req;
        n_idx    = r_idx;
        n_status = r_status;
        n_grant  = r_grant;

        o_ram_we      = 1'b0;
        o_ram_waddr   = r_addr;
        o_ram_wdata   = {sweep_link, SIZE_W'(0)};
        o_ram_re      = 1'b0;
        o_ram_raddr   = r_head[IDX_W-1:0];
        o_push        = 1'b0;
        o_push_status = r_status;
        o_push_grant  = r_grant;

        unique case (r_state)
            S_SWEEP: begin
                // one entry a cycle: rebuild link, clear record
                o_ram_we = 1'b1;
                n_addr   = r_addr + IDX_W'(1);
                n_acc    = r_acc + BB_ACC;
                if (r_addr == LAST_ADDR) begin
                    n_state = r_reply ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_req    = req_ext[SIZE_W-1:0];
                    n_idx    = i_idx;
                    n_grant  = '0;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    unique case (i_mode)
                        MODE_ALLOC: begin
                            if (too_large) begin
                                n_status = ST_TOO_LARGE;
                            end else if (head_null) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = r_head[IDX_W-1:0];
                                n_state     = S_RMW;
                            end
                        end
                        MODE_FREE: begin
                            if (i_is_null || idx_out) begin
                                n_status = ST_IGNORED;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = i_idx;
                                n_state     = S_RMW;
                            end
                        end
                        MODE_INIT: begin
                            if (pool_small) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_head  = '0;
                                n_addr  = '0;
                                n_acc   = ACC_START;
                                n_init  = 1'b1;
                                n_reply = 1'b1;
                                n_state = S_SWEEP;
                            end
                        end
                        MODE_DESTROY: begin
                            n_head  = NULL_LINK;
                            n_addr  = '0;
                            n_acc   = ACC_START;
                            n_init  = 1'b0;
                            n_reply = 1'b1;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RMW: begin
                // entry read at accept is now on i_ram_rdata
                if (r_mode == MODE_ALLOC) begin
                    o_push_status = ST_OK;
                    o_push_grant  = r_head[IDX_W-1:0];
                    o_ram_waddr   = r_head[IDX_W-1:0];
                    o_ram_wdata   = {rd_link, r_req};
                    if (i_push_ready) begin
                        o_ram_we = 1'b1;
                        n_head   = rd_link_sat;
                    end
                end else begin
                    o_push_grant = '0;
                    o_ram_waddr  = r_idx;
                    o_ram_wdata  = {r_head, SIZE_W'(0)};
                    if (rd_size == '0) begin
                        o_push_status = ST_IGNORED;
                    end else begin
                        o_push_status = ST_OK;
                        if (i_push_ready) begin
                            o_ram_we = 1'b1;
                            n_head   = LINK_W'(r_idx);
                        end
                    end
                end
                if (i_push_ready) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_push_ready) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_head  <= NULL_LINK;
            r_addr  <= '0;
            r_acc   <= ACC_START;
            r_init  <= 1'b0;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_addr  <= n_addr;
            r_acc   <= n_acc;
            r_init  <= n_init;
            r_reply <= n_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

`ifndef SYNTHESIS
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NULL_LINK)
        else $error("free list head beyond null link");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_SWEEP || r_state == S_RMW))
        else $error("entry write outside sweep or update");

    a_read_to_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |=> (r_state == S_RMW))
        else $error("entry read not followed by update");

    a_rmw_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && !i_push_ready) |=>
            (r_state == S_RMW && $stable(i_ram_rdata)))
        else $error("read data lost while result stalled");
`endif

endmodule

/* hw/rtl/fixed_block_free_list_allocator.sv */
// fixed-size block allocator: a pool of BLOCK_BYTES blocks kept as a LIFO free
// list of block indices, link and recorded size of each block in one RAM
//
// s_axis carries commands: tuser selects alloc, free, init or destroy, tdata
// holds the request size and the block handed back by free. m_axis returns
// one result transaction per command: status in tuser, granted block in tdata.
// the pool size register (i_cfg_wr_*) is read by init only
//
// alloc and free read the entry RAM at accept; the read-modify-write completes
// in the update state once the output register has room, where the result is
// loaded into that register. rejected commands wait in a response state instead
// init (unless refused) and destroy sweep every entry, one per cycle
//
// after reset the same sweep runs over every entry, clearing all records
// and links with s_axis_tready low; configuration writes are taken throughout
// a waiting result sits in the output register, so the next command is taken
// while m_axis stalls; a second result waits in the controller until the
// register drains
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS  = fbfl_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = fbfl_pkg::DEF_BLOCK_BYTES,
    localparam int IDX_W      = $clog2(MAX_BLOCKS),
    localparam int IN_DATA_W  = ((fbfl_pkg::REQ_W + IDX_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((IDX_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pool size in bytes
    input  logic                        i_cfg_wr_en,
    input  logic [fbfl_pkg::POOL_W-1:0] i_cfg_wr_data,
    // command channel
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_DATA_W-1:0]        s_axis_tdata,  // request_size, block_index, zero pad
    input  logic [2:0]                  s_axis_tuser,  // mode, block_is_null
    // result channel
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,  // granted_index, zero pad
    output logic [2:0]                  m_axis_tuser   // status
);

    import fbfl_pkg::*;

    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W = $clog2(BLOCK_BYTES + 1);
    localparam int ENT_W  = LINK_W + SIZE_W;

    // command fields
    t_mode             in_mode;
    logic [REQ_W-1:0]  in_req;
    logic [IDX_W-1:0]  in_idx;
    logic              in_is_null;

    // entry RAM port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    // result handoff
    logic              push;
    logic              push_ready;
    t_status           push_status;
    logic [IDX_W-1:0]  push_grant;

    assign in_mode    = t_mode'(s_axis_tuser[MODE_W-1:0]);
    assign in_is_null = s_axis_tuser[MODE_W];
    assign in_req     = s_axis_tdata[REQ_W-1:0];
    assign in_idx     = s_axis_tdata[REQ_W +: IDX_W];

    // sequencer: decode, entry read-modify-write, init/destroy/reset sweep
    fbfl_ctrl #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_mode        (in_mode),
        .i_req         (in_req),
        .i_idx         (in_idx),
        .i_is_null     (in_is_null),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .i_push_ready  (push_ready),
        .o_push        (push),
        .o_push_status (push_status),
        .o_push_grant  (push_grant)
    );

    // per block: {next link, recorded size}
    fbfl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_BLOCKS)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // output register decouples the result channel from the sequencer
    fbfl_out_slot #(
        .DATA_W (OUT_DATA_W),
        .USER_W (STATUS_W)
    ) u_out_slot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (OUT_DATA_W'(push_grant)),
        .i_user       (push_status),
        .o_push_ready (push_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_user       (m_axis_tuser)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

// testbench for the fixed-size block allocator
//
// commands go in on s_axis, one result comes back on m_axis for each command.
// a predictor in this file mirrors the free list, the per-block size records
// and the pool size register, and it queues the expected status and granted
// block for every accepted command. a checker pops that queue on each result
// transaction and compares it field by field.
// a short directed part covers the corner cases, then randomized traffic runs
// over a range of pool sizes. that traffic is mostly legal alloc/free
// sequences, plus init, destroy and junk commands.
module testbench;
    import fbfl_pkg::*;

    localparam int MAX_BLOCKS  = DEF_MAX_BLOCKS;
    localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int IN_DATA_W   = ((REQ_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((IDX_W + 7) / 8) * 8;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // wait that covers an init/destroy sweep, also the settle time before a register write
    localparam int SWEEP_CYCLES = MAX_BLOCKS + 4;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted;
    } t_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [POOL_W-1:0]     i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // request_size, block_index, zero pad
    logic [2:0]            s_axis_tuser  = '0;  // mode, block_is_null
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // granted_index, zero pad
    logic [2:0]            m_axis_tuser;        // status

    // predicted allocator state
    logic [6:0]        link_mem [MAX_BLOCKS];
    logic [10:0]       size_rec [MAX_BLOCKS];
    logic [6:0]        list_head = 7'(MAX_BLOCKS);
    logic [POOL_W-1:0] pool_bytes = '0;

    // expected results, oldest first
    t_result pending_results[$];
    t_result head_result;

    int mismatches    = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    bit tx_steady     = 1'b0;
    int cmd_count [4] = '{default: 0};
    int status_count [5] = '{default: 0};
    int grant_count   = 0;
    int pool_settings = 0;

    // receiver pattern state
    int       rx_style = 0;
    int       rx_span  = 0;
    bit [3:0] rx_tick  = '0;

    always #5 i_clk = ~i_clk;

    fixed_block_free_list_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // result side backpressure: switches between several stall styles,
    // each held for a random span, including a span with no stalls at all
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_span  <= $urandom_range(20, 120);
        end else begin
            rx_span <= rx_span - 1;
        end
        rx_tick <= rx_tick + 1'b1;
        case (rx_style)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 1) == 0);
            end
            default: begin
                // long stalls: ready for one cycle whenever rx_tick wraps to zero
                m_axis_tready <= (rx_tick == 4'd0);
            end
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status",
                                int'(m_axis_tuser), -1);
            end else begin
                head_result = pending_results.pop_front();
                if (m_axis_tuser != head_result.status)
                    report_mismatch("status", int'(m_axis_tuser), int'(head_result.status));
                if (m_axis_tdata[IDX_W-1:0] != head_result.granted)
                    report_mismatch("granted block", int'(m_axis_tdata[IDX_W-1:0]),
                                    int'(head_result.granted));
            end
        end
    end

    // hang detection: any transaction on either channel resets the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // allocator behavior for one command; updates the predicted state
    function automatic t_result model_command(input t_mode mode, input logic [15:0] req,
                                              input logic [IDX_W-1:0] idx, input logic nul);
        t_result    r;
        logic [6:0] nxt;
        int         count;
        r.status  = ST_OK;
        r.granted = '0;
        case (mode)
            MODE_ALLOC: begin
                if (req > BLOCK_BYTES) begin
                    r.status = ST_TOO_LARGE;
                end else if (list_head >= MAX_BLOCKS) begin
                    r.status = ST_EMPTY;
                end else begin
                    nxt = link_mem[list_head];
                    r.granted = list_head[IDX_W-1:0];
                    size_rec[list_head] = req[10:0];
                    // a link beyond the null value still ends the list
                    list_head = (nxt > MAX_BLOCKS) ? 7'(MAX_BLOCKS) : nxt;
                    grant_count++;
                end
            end
            MODE_FREE: begin
                // zero record means not allocated, which includes zero-size allocs
                if (nul || size_rec[idx] == 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    size_rec[idx] = '0;
                    link_mem[idx] = list_head;
                    list_head     = 7'(idx);
                end
            end
            MODE_INIT: begin
                if (pool_bytes <= BLOCK_BYTES) begin
                    r.status = ST_REFUSED;
                end else begin
                    count = pool_bytes / BLOCK_BYTES;
                    if (count > MAX_BLOCKS)
                        count = MAX_BLOCKS;
                    for (int b = 0; b < MAX_BLOCKS; b++)
                        size_rec[b] = '0;
                    for (int b = 0; b < count; b++)
                        link_mem[b] = (b + 1 < count) ? 7'(b + 1) : 7'(MAX_BLOCKS);
                    list_head = '0;
                end
            end
            default: begin
                for (int b = 0; b < MAX_BLOCKS; b++)
                    size_rec[b] = '0;
                list_head = 7'(MAX_BLOCKS);
            end
        endcase
        return r;
    endfunction

    // drive one command and wait for it to be taken; bursts end in a random gap
    task automatic send_command(input t_mode mode, input logic [15:0] req,
                                input logic [IDX_W-1:0] idx, input logic nul);
        t_result r;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = tx_steady ? 1_000_000 : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({idx, req});
        s_axis_tuser  <= {nul, mode};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = model_command(mode, req, idx, nul);
        pending_results.push_back(r);
        cmd_count[mode]++;
        status_count[r.status]++;
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic sender_idle();
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // the register is only touched once the block has gone quiet
    task automatic set_pool_size(input logic [POOL_W-1:0] value);
        sender_idle();
        wait_drained();
        repeat (SWEEP_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        pool_bytes = value;
        pool_settings++;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_after_reset();
        set_pool_size('0);
        send_command(MODE_ALLOC, 16'd16, '0, 1'b0);      // empty list
        send_command(MODE_FREE, '0, IDX_W'(5), 1'b0);    // never allocated
        send_command(MODE_INIT, '0, '0, 1'b0);           // zero pool refused
        send_command(MODE_DESTROY, '0, '0, 1'b0);
    endtask

    task automatic test_init_refusal();
        set_pool_size(20'(BLOCK_BYTES));                 // exactly one block
        send_command(MODE_INIT, '0, '0, 1'b0);
        set_pool_size(20'(BLOCK_BYTES + 1));             // one usable block
        send_command(MODE_INIT, '0, '0, 1'b0);
        send_command(MODE_ALLOC, 16'(BLOCK_BYTES), '0, 1'b0);
        send_command(MODE_ALLOC, 16'd1, '0, 1'b0);       // list ran dry
    endtask

    task automatic test_alloc_free_cases();
        set_pool_size('1);                               // block count saturates
        send_command(MODE_INIT, '0, '0, 1'b0);
        send_command(MODE_ALLOC, 16'hFFFF, '1, 1'b1);
        send_command(MODE_ALLOC, 16'(BLOCK_BYTES + 1), '0, 1'b0);
        send_command(MODE_ALLOC, 16'd0, '0, 1'b0);       // zero size, record stays 0
        send_command(MODE_FREE, '0, IDX_W'(0), 1'b0);    // so this free is ignored
        send_command(MODE_ALLOC, 16'd1, '0, 1'b0);
        send_command(MODE_FREE, '0, IDX_W'(1), 1'b1);    // null handle
        send_command(MODE_FREE, '0, IDX_W'(1), 1'b0);
        send_command(MODE_FREE, '0, IDX_W'(1), 1'b0);    // double free
        send_command(MODE_ALLOC, 16'd7, '0, 1'b0);       // lifo: block 1 again
        send_command(MODE_INIT, '0, '0, 1'b0);           // rebuild while in use
        send_command(MODE_FREE, '0, IDX_W'(1), 1'b0);
        send_command(MODE_ALLOC, 16'd100, '0, 1'b0);
        send_command(MODE_DESTROY, '0, '0, 1'b0);
        send_command(MODE_FREE, '0, IDX_W'(0), 1'b0);    // held before destroy
        send_command(MODE_ALLOC, 16'd100, '0, 1'b0);
        send_command(MODE_FREE, '0, '1, 1'b0);
    endtask

    function automatic int pick_held_block();
        int held[$];
        for (int b = 0; b < MAX_BLOCKS; b++)
            if (size_rec[b] != 0)
                held.push_back(b);
        if (held.size() == 0)
            return -1;
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    // one pool setting: init first, then mostly legal alloc/free traffic
    task automatic run_traffic_phase(input logic [POOL_W-1:0] pool, input int n_items,
                                     input bit steady);
        int          roll;
        int          pick;
        int          blk;
        logic [15:0] req;
        set_pool_size(pool);
        tx_steady = steady;
        send_command(MODE_INIT, 16'($urandom), IDX_W'($urandom), 1'($urandom));
        for (int k = 1; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 19);
            if (roll < 48) begin
                if (pick == 0)
                    req = '0;
                else if (pick == 1)
                    req = 16'(BLOCK_BYTES);
                else if (pick < 4)
                    req = 16'($urandom_range(BLOCK_BYTES + 1, 16'hFFFF));
                else
                    req = 16'($urandom_range(1, BLOCK_BYTES));
                send_command(MODE_ALLOC, req, IDX_W'($urandom), 1'b0);
            end else if (roll < 90) begin
                blk = pick_held_block();
                if (blk < 0 || pick >= 16)
                    blk = $urandom_range(0, MAX_BLOCKS - 1);
                // occasional null handle, sometimes on a block that is really held
                send_command(MODE_FREE, 16'($urandom), IDX_W'(blk), pick < 2);
            end else if (roll < 95) begin
                send_command(MODE_INIT, 16'($urandom), IDX_W'($urandom), 1'($urandom));
            end else if (roll < 98) begin
                send_command(MODE_DESTROY, 16'($urandom), IDX_W'($urandom), 1'($urandom));
            end else begin
                send_command(t_mode'($urandom_range(0, 3)), 16'($urandom),
                             IDX_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [POOL_W-1:0] pools [10];
        pools = '{20'hFFFFF, 20'd65536, 20'(BLOCK_BYTES + 1), 20'd0, 20'd3000,
                  20'($urandom_range(BLOCK_BYTES + 1, 20'hFFFFF)), 20'(BLOCK_BYTES),
                  20'd2048, 20'($urandom), 20'd40000};
        for (int p = 0; p < 10; p++)
            run_traffic_phase(pools[p], (pools[p] <= BLOCK_BYTES) ? 20 : 75, p % 2 == 0);
    endtask

    initial begin
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            link_mem[b] = '0;
            size_rec[b] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_init_refusal();
        test_alloc_free_cases();
        test_random_traffic();

        // let the last results and any trailing sweep finish
        sender_idle();
        wait_drained();
        repeat (SWEEP_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        $display("ran %0d commands over %0d pool sizes: %0d alloc, %0d free, %0d init, %0d destroy",
                 cmd_count.sum(), pool_settings, cmd_count[MODE_ALLOC], cmd_count[MODE_FREE],
                 cmd_count[MODE_INIT], cmd_count[MODE_DESTROY]);
        $display("outcomes: %0d grants, %0d too large, %0d list empty, %0d ignored, %0d refused",
                 grant_count, status_count[ST_TOO_LARGE], status_count[ST_EMPTY],
                 status_count[ST_IGNORED], status_count[ST_REFUSED]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
